### hdl/gwc_pkg.sv
// ----------------------------------------------------------------------------
// gwc_pkg
// Shared field widths, codes and control structs of the window convolution.
// ----------------------------------------------------------------------------
`default_nettype none

package gwc_pkg;

    localparam int MODE_W     = 2;
    localparam int POS_W      = 6;
    localparam int VALUE_W    = 17;
    localparam int PIX_W      = 8;
    localparam int WGT_W      = 17;
    localparam int PROD_W     = PIX_W + WGT_W;
    localparam int FRAC_W     = 16;
    localparam int DIM_W      = 7;
    localparam int KSIZE_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [MODE_W-1:0] MODE_PIXEL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WEIGHT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd2;

    localparam logic [DIM_W-1:0]   WIDTH_RST  = 7'd64;
    localparam logic [DIM_W-1:0]   HEIGHT_RST = 7'd64;
    localparam logic [KSIZE_W-1:0] KERNEL_RST = 4'd3;

    typedef struct packed {
        logic clear;
        logic valid;
        logic last;
    } t_mac_ctrl;

    typedef struct packed {
        logic done;
    } t_mac_stat;

endpackage

`default_nettype wire

### hdl/gaussian_window_convolution_unit.sv
// ----------------------------------------------------------------------------
// gaussian_window_convolution_unit
// Frame and kernel stores with a sequenced multiply-accumulate over a window.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | sink      | i_in_valid / o_in_ready   | i_mode i_row i_col i_value
//  out     | source    | o_out_valid / i_out_ready | o_blurred_pixel o_saturated
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index i_cfg_data
//
//  pixel and weight words are accepted whenever the input is ready
//  a compute word runs setup, then k*k window reads (k = effective kernel side) into
//  the single multiply-accumulate unit, one frame and one weight read a cycle
//  the input is not ready while a compute word is in flight
//  a finished result waits in the output register without blocking new loads
//  a compute word holds in its last cycle while the previous result still waits
//  synchronous active-low reset; stores hold no reset state
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_window_convolution_unit
    import gwc_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_KERNEL = 15
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [MODE_W-1:0]     i_mode,
    input  wire logic [POS_W-1:0]      i_row,
    input  wire logic [POS_W-1:0]      i_col,
    input  wire logic [VALUE_W-1:0]    i_value,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [PIX_W-1:0]      o_blurred_pixel,
    output logic                       o_saturated,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int FDEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int FA_W   = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
    localparam int WDEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int ACC_W  = PROD_W + ((WDEPTH > 1) ? $clog2(WDEPTH) : 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_RUN,
        S_WAIT,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [DIM_W-1:0]     r_cfg_width;
    logic [DIM_W-1:0]     r_cfg_height;
    logic [KSIZE_W-1:0]   r_cfg_kernel;
    logic [POS_W-1:0]     r_row;
    logic [POS_W-1:0]     r_col;
    logic [POS_W-1:0]     r_r0;
    logic [POS_W-1:0]     r_c0;
    logic [KSIZE_W-1:0]   r_k;
    logic [KSIZE_W-1:0]   r_ki;
    logic [KSIZE_W-1:0]   r_kj;
    logic                 r_iss_vld;
    logic                 r_iss_last;
    logic                 r_out_valid;
    logic [PIX_W-1:0]     r_out_pixel;
    logic                 r_out_sat;

    logic                 in_acc;
    logic [DIM_W-1:0]     w_eff;
    logic [DIM_W-1:0]     h_eff;
    logic [KSIZE_W-1:0]   k_eff;
    logic [DIM_W-1:0]     half;
    logic [DIM_W-1:0]     row_cl;
    logic [DIM_W-1:0]     col_cl;
    logic [DIM_W-1:0]     r0_s;
    logic [DIM_W-1:0]     c0_s;
    logic [DIM_W-1:0]     r0_lim;
    logic [DIM_W-1:0]     c0_lim;
    logic [DIM_W-1:0]     n_r0;
    logic [DIM_W-1:0]     n_c0;
    logic                 iss_last;
    logic                 issue;

    logic                 pix_wr_en;
    logic [FA_W-1:0]      pix_wr_addr;
    logic [FA_W-1:0]      pix_rd_addr;
    logic [PIX_W-1:0]     pix_rd_data;
    logic                 wgt_wr_en;
    logic [WA_W-1:0]      wgt_wr_addr;
    logic [WA_W-1:0]      wgt_rd_addr;
    logic [WGT_W-1:0]     wgt_rd_data;

    t_mac_ctrl            mac_ctrl;
    t_mac_stat            mac_stat;
    logic [ACC_W-1:0]     mac_acc;
    logic                 acc_sat;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid & o_in_ready;

    // effective frame and kernel sizes, clamped request position and window origin
    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = r_cfg_width;
        end
        if (r_cfg_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (32'(r_cfg_height) > MAX_HEIGHT) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_cfg_height;
        end
        k_eff = (r_cfg_kernel == '0) ? KSIZE_W'(1) : r_cfg_kernel;
        if (32'(k_eff) > MAX_KERNEL) begin
            k_eff = KSIZE_W'(MAX_KERNEL);
        end
        if (DIM_W'(k_eff) > w_eff) begin
            k_eff = w_eff[KSIZE_W-1:0];
        end
        if (DIM_W'(k_eff) > h_eff) begin
            k_eff = h_eff[KSIZE_W-1:0];
        end
        half   = DIM_W'(k_eff - KSIZE_W'(1)) >> 1;
        row_cl = (DIM_W'(r_row) >= h_eff) ? h_eff - DIM_W'(1) : DIM_W'(r_row);
        col_cl = (DIM_W'(r_col) >= w_eff) ? w_eff - DIM_W'(1) : DIM_W'(r_col);
        r0_s   = (row_cl > half) ? row_cl - half : '0;
        c0_s   = (col_cl > half) ? col_cl - half : '0;
        r0_lim = h_eff - DIM_W'(k_eff);
        c0_lim = w_eff - DIM_W'(k_eff);
        n_r0   = (r0_s > r0_lim) ? r0_lim : r0_s;
        n_c0   = (c0_s > c0_lim) ? c0_lim : c0_s;
    end

    // store writes
    assign pix_wr_en   = in_acc && (i_mode == MODE_PIXEL) &&
                         (32'(i_row) < MAX_HEIGHT) && (32'(i_col) < MAX_WIDTH);
    assign pix_wr_addr = FA_W'(32'(i_row) * MAX_WIDTH + 32'(i_col));
    assign wgt_wr_en   = in_acc && (i_mode == MODE_WEIGHT) &&
                         (32'(i_row) < MAX_KERNEL) && (32'(i_col) < MAX_KERNEL);
    assign wgt_wr_addr = WA_W'(32'(i_row) * MAX_KERNEL + 32'(i_col));

    // window reads
    assign issue       = (r_state == S_RUN);
    assign iss_last    = (r_ki == r_k - KSIZE_W'(1)) && (r_kj == r_k - KSIZE_W'(1));
    assign pix_rd_addr = FA_W'((32'(r_r0) + 32'(r_ki)) * MAX_WIDTH +
                               32'(r_c0) + 32'(r_kj));
    assign wgt_rd_addr = WA_W'(32'(r_ki) * MAX_KERNEL + 32'(r_kj));

    gwc_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (FDEPTH),
        .ADDR_W (FA_W)
    ) u_frame (
        .i_clk     (i_clk),
        .i_wr_en   (pix_wr_en),
        .i_wr_addr (pix_wr_addr),
        .i_wr_data (i_value[PIX_W-1:0]),
        .i_rd_en   (issue),
        .i_rd_addr (pix_rd_addr),
        .o_rd_data (pix_rd_data)
    );

    gwc_ram #(
        .DATA_W (WGT_W),
        .DEPTH  (WDEPTH),
        .ADDR_W (WA_W)
    ) u_weight (
        .i_clk     (i_clk),
        .i_wr_en   (wgt_wr_en),
        .i_wr_addr (wgt_wr_addr),
        .i_wr_data (i_value[WGT_W-1:0]),
        .i_rd_en   (issue),
        .i_rd_addr (wgt_rd_addr),
        .o_rd_data (wgt_rd_data)
    );

    assign mac_ctrl.clear = (r_state == S_SETUP);
    assign mac_ctrl.valid = r_iss_vld;
    assign mac_ctrl.last  = r_iss_last;

    gwc_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_pix   (pix_rd_data),
        .i_wgt   (wgt_rd_data),
        .o_stat  (mac_stat),
        .o_acc   (mac_acc)
    );

    assign acc_sat = |mac_acc[ACC_W-1:FRAC_W+PIX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_width  <= WIDTH_RST;
            r_cfg_height <= HEIGHT_RST;
            r_cfg_kernel <= KERNEL_RST;
            r_iss_vld    <= 1'b0;
            r_iss_last   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_cfg_width  <= i_cfg_data;
                    CFG_HEIGHT: r_cfg_height <= i_cfg_data;
                    CFG_KERNEL: r_cfg_kernel <= i_cfg_data[KSIZE_W-1:0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            r_iss_vld  <= issue;
            r_iss_last <= issue & iss_last;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_mode == MODE_COMPUTE)) begin
                        r_row   <= i_row;
                        r_col   <= i_col;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_r0    <= n_r0[POS_W-1:0];
                    r_c0    <= n_c0[POS_W-1:0];
                    r_k     <= k_eff;
                    r_ki    <= '0;
                    r_kj    <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (iss_last) begin
                        r_state <= S_WAIT;
                    end else if (r_kj == r_k - KSIZE_W'(1)) begin
                        r_kj <= '0;
                        r_ki <= r_ki + KSIZE_W'(1);
                    end else begin
                        r_kj <= r_kj + KSIZE_W'(1);
                    end
                end
                S_WAIT: begin
                    if (mac_stat.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_pixel <= acc_sat ? '1 : mac_acc[FRAC_W +: PIX_W];
                        r_out_sat   <= acc_sat;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_blurred_pixel = r_out_pixel;
    assign o_saturated     = r_out_sat;

endmodule

`default_nettype wire

### hdl/gwc_ram.sv
// ----------------------------------------------------------------------------
// gwc_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gwc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hdl/gwc_mac.sv
// ----------------------------------------------------------------------------
// gwc_mac
// Shared multiply-accumulate unit: registered product, then accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module gwc_mac
    import gwc_pkg::*;
#(
    parameter int ACC_W = 33
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_mac_ctrl        i_ctrl,
    input  wire logic [PIX_W-1:0] i_pix,
    input  wire logic [WGT_W-1:0] i_wgt,
    output t_mac_stat             o_stat,
    output logic      [ACC_W-1:0] o_acc
);

    logic [PROD_W-1:0] r_prod;
    logic              r_prod_vld;
    logic              r_prod_last;
    logic [ACC_W-1:0]  r_acc;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_pix) * PROD_W'(i_wgt);
        if (!i_rst_n) begin
            r_prod_vld  <= 1'b0;
            r_prod_last <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_prod_vld  <= i_ctrl.valid;
            r_prod_last <= i_ctrl.valid & i_ctrl.last;
            r_done      <= r_prod_vld & r_prod_last;
        end
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_stat.done = r_done;
    assign o_acc       = r_acc;

endmodule

`default_nettype wire

### hdl/gwc_checker.sv
// ----------------------------------------------------------------------------
// gwc_checker
// Port-level checks of the window convolution unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gwc_checker
    import gwc_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_ready,
    input wire logic [MODE_W-1:0]    i_mode,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [PIX_W-1:0]     o_blurred_pixel,
    input wire logic                 o_saturated
);

    // result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_blurred_pixel) && $stable(o_saturated))
        else $error("result word changed while stalled");

    // clamped result is full scale
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |-> o_blurred_pixel == '1)
        else $error("saturated result below full scale");

    // a compute word blocks the input
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_mode == MODE_COMPUTE |=> !o_in_ready)
        else $error("input ready during compute");

    // load words never raise a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_mode != MODE_COMPUTE && !o_out_valid
            |=> !o_out_valid)
        else $error("result without compute word");

endmodule

bind gaussian_window_convolution_unit gwc_checker u_gwc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_mode          (i_mode),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_blurred_pixel (o_blurred_pixel),
    .o_saturated     (o_saturated)
);

`default_nettype wire

### tb/gaussian_window_convolution_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_window_convolution_unit_tb
// Loads frame pixels and kernel weights, then requests blurred pixels over a
// range of frame and kernel sizes. A behavioral predictor tracks both stores
// and checks every result word and saturation flag in order, with random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module gaussian_window_convolution_unit_tb;

    import gwc_pkg::*;

    localparam int FRAME_W_MAX = 64;
    localparam int FRAME_H_MAX = 64;
    localparam int KERN_MAX    = 15;

    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    localparam int KW_NORMAL = 0;
    localparam int KW_HEAVY  = 1;
    localparam int KW_SPIKY  = 2;

    localparam int SETTLE_CYCLES = KERN_MAX * KERN_MAX + 15;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [VALUE_W-1:0] value;
    } in_word_t;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             sat;
    } blur_t;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    wire                   in_ready;
    logic [MODE_W-1:0]     mode      = '0;
    logic [POS_W-1:0]      row       = '0;
    logic [POS_W-1:0]      col       = '0;
    logic [VALUE_W-1:0]    value     = '0;
    wire                   out_valid;
    logic                  out_ready = 1'b0;
    wire  [PIX_W-1:0]      blurred_pixel;
    wire                   saturated;
    logic                  cfg_valid = 1'b0;
    wire                   cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor state
    logic [PIX_W-1:0]   frame_mem  [FRAME_W_MAX*FRAME_H_MAX];
    logic [WGT_W-1:0]   kernel_mem [KERN_MAX*KERN_MAX];
    logic [DIM_W-1:0]   cfg_width;
    logic [DIM_W-1:0]   cfg_height;
    logic [KSIZE_W-1:0] cfg_kernel;

    // stimulus bookkeeping
    bit pix_loaded [FRAME_W_MAX*FRAME_H_MAX];
    bit wgt_loaded [KERN_MAX*KERN_MAX];

    in_word_t    pending_words[$];
    blur_t       blur_expected[$];
    blur_t       blur_want;
    int unsigned phase_words   = 0;
    int unsigned in_gap_pct    = 20;
    int unsigned out_stall_pct = 20;
    int unsigned in_gap_cnt    = 0;
    int unsigned out_stall_cnt = 0;
    int unsigned out_hold_cnt  = 0;
    int unsigned rx_cnt        = 0;
    int unsigned cycle_cnt     = 0;
    int unsigned err_cnt       = 0;

    gaussian_window_convolution_unit #(
        .MAX_WIDTH  (FRAME_W_MAX),
        .MAX_HEIGHT (FRAME_H_MAX),
        .MAX_KERNEL (KERN_MAX)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_mode          (mode),
        .i_row           (row),
        .i_col           (col),
        .i_value         (value),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_blurred_pixel (blurred_pixel),
        .o_saturated     (saturated),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // effective frame and kernel geometry from the register values
    function automatic void eff_geom(output int unsigned w, output int unsigned h,
                                     output int unsigned k);
        w = (cfg_width == 0) ? 1 : ((cfg_width > FRAME_W_MAX) ? FRAME_W_MAX : cfg_width);
        h = (cfg_height == 0) ? 1 : ((cfg_height > FRAME_H_MAX) ? FRAME_H_MAX : cfg_height);
        k = (cfg_kernel == 0) ? 1 : ((cfg_kernel > KERN_MAX) ? KERN_MAX : cfg_kernel);
        if (k > w) k = w;
        if (k > h) k = h;
    endfunction

    function automatic int unsigned win_origin(int unsigned pos, int unsigned half,
                                               int unsigned dim, int unsigned k);
        int unsigned s;
        s = (pos > half) ? pos - half : 0;
        if (s > dim - k) s = dim - k;
        return s;
    endfunction

    function automatic void predict_blur(logic [POS_W-1:0] r_in, logic [POS_W-1:0] c_in);
        int unsigned w, h, k, half, r, c, r0, c0, ki, kj;
        logic [63:0] acc;
        logic [63:0] q;
        blur_t res;
        eff_geom(w, h, k);
        half = (k - 1) / 2;
        r = (r_in >= h) ? h - 1 : r_in;
        c = (c_in >= w) ? w - 1 : c_in;
        r0 = win_origin(r, half, h, k);
        c0 = win_origin(c, half, w, k);
        acc = '0;
        for (ki = 0; ki < k; ki++) begin
            for (kj = 0; kj < k; kj++) begin
                acc += 64'(frame_mem[(r0 + ki) * FRAME_W_MAX + c0 + kj])
                     * 64'(kernel_mem[ki * KERN_MAX + kj]);
            end
        end
        q = acc >> FRAC_W;
        res.sat   = (q > 255);
        res.pixel = res.sat ? 8'hFF : q[PIX_W-1:0];
        blur_expected.push_back(res);
    endfunction

    function automatic void apply_word(in_word_t w);
        case (w.mode)
            MODE_PIXEL: begin
                frame_mem[w.row * FRAME_W_MAX + w.col] = w.value[PIX_W-1:0];
            end
            MODE_WEIGHT: begin
                if (w.row < KERN_MAX && w.col < KERN_MAX)
                    kernel_mem[w.row * KERN_MAX + w.col] = w.value;
            end
            MODE_COMPUTE: begin
                predict_blur(w.row, w.col);
            end
            default: ;
        endcase
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid   <= 1'b0;
            in_gap_cnt <= 0;
        end else if (!in_valid || in_ready) begin
            if (in_gap_cnt != 0) begin
                in_gap_cnt <= in_gap_cnt - 1;
                in_valid   <= 1'b0;
            end else if (pending_words.size() != 0 && $urandom_range(99) < in_gap_pct) begin
                in_gap_cnt <= $urandom_range(5);
                in_valid   <= 1'b0;
            end else if (pending_words.size() != 0) begin
                in_valid <= 1'b1;
                mode     <= pending_words[0].mode;
                row      <= pending_words[0].row;
                col      <= pending_words[0].col;
                value    <= pending_words[0].value;
                pending_words.delete(0);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready     <= 1'b0;
            out_stall_cnt <= 0;
            out_hold_cnt  <= 0;
            rx_cnt        <= 0;
        end else begin
            if (out_valid && out_ready)
                rx_cnt <= rx_cnt + 1;
            if (out_hold_cnt != 0) begin
                out_hold_cnt <= out_hold_cnt - 1;
                out_ready    <= 1'b0;
            end else if (out_valid && out_ready && (rx_cnt == 29 || rx_cnt == 59)) begin
                out_hold_cnt <= LONG_HOLD;
                out_ready    <= 1'b0;
            end else if (out_stall_cnt != 0) begin
                out_stall_cnt <= out_stall_cnt - 1;
                out_ready     <= 1'b0;
            end else if ($urandom_range(99) < out_stall_pct) begin
                out_stall_cnt <= $urandom_range(5);
                out_ready     <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // register shadow
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width  <= WIDTH_RST;
            cfg_height <= HEIGHT_RST;
            cfg_kernel <= KERNEL_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WIDTH:  cfg_width  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT: cfg_height <= cfg_data[DIM_W-1:0];
                CFG_KERNEL: cfg_kernel <= cfg_data[KSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // accepted input words
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && in_ready)
            apply_word('{mode, row, col, value});
    end

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (blur_expected.size() == 0) begin
                err_cnt <= err_cnt + 1;
                $display("%0t: unexpected result: expected none, got pixel %0d sat %0d",
                         $time, blurred_pixel, saturated);
            end else begin
                blur_want = blur_expected.pop_front();
                if (blurred_pixel !== blur_want.pixel || saturated !== blur_want.sat)
                    err_cnt <= err_cnt + 1;
                if (blurred_pixel !== blur_want.pixel)
                    $display("%0t: blurred_pixel mismatch: expected %0d, got %0d",
                             $time, blur_want.pixel, blurred_pixel);
                if (saturated !== blur_want.sat)
                    $display("%0t: saturated mismatch: expected %0d, got %0d",
                             $time, blur_want.sat, saturated);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_word(logic [MODE_W-1:0] m, int unsigned r, int unsigned c,
                             int unsigned v);
        in_word_t w;
        w.mode  = m;
        w.row   = r[POS_W-1:0];
        w.col   = c[POS_W-1:0];
        w.value = v[VALUE_W-1:0];
        pending_words.push_back(w);
        if (m == MODE_PIXEL) begin
            pix_loaded[w.row * FRAME_W_MAX + w.col] = 1'b1;
            phase_words++;
        end else if (m == MODE_WEIGHT && w.row < KERN_MAX && w.col < KERN_MAX) begin
            wgt_loaded[w.row * KERN_MAX + w.col] = 1'b1;
            phase_words++;
        end else if (m == MODE_COMPUTE) begin
            phase_words++;
        end
    endtask

    function automatic int unsigned weight_value(int style, int unsigned k);
        case (style)
            KW_NORMAL: return $urandom_range(131072 / (k * k), 0);
            KW_HEAVY:  return $urandom_range(65536, 0);
            default:   return ($urandom_range(9) == 0) ? 65536 : $urandom_range(8192, 0);
        endcase
    endfunction

    function automatic int unsigned pos_pick(int unsigned dim);
        if ($urandom_range(3) != 0)
            return $urandom_range(dim - 1, 0);
        return $urandom_range(63, 0);
    endfunction

    // queue a blur request, loading any window entry not yet written
    task automatic queue_blur(int unsigned r_in, int unsigned c_in, int style);
        int unsigned w, h, k, half, r, c, r0, c0, i, j;
        eff_geom(w, h, k);
        half = (k - 1) / 2;
        r = (r_in >= h) ? h - 1 : r_in;
        c = (c_in >= w) ? w - 1 : c_in;
        r0 = win_origin(r, half, h, k);
        c0 = win_origin(c, half, w, k);
        for (i = 0; i < k; i++) begin
            for (j = 0; j < k; j++) begin
                if (!pix_loaded[(r0 + i) * FRAME_W_MAX + c0 + j])
                    push_word(MODE_PIXEL, r0 + i, c0 + j, $urandom_range(65536, 0));
                if (!wgt_loaded[i * KERN_MAX + j])
                    push_word(MODE_WEIGHT, i, j, weight_value(style, k));
            end
        end
        push_word(MODE_COMPUTE, r_in, c_in, $urandom_range(65536, 0));
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || in_valid || blur_expected.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] wd, logic [CFG_DATA_W-1:0] hd,
                             logic [CFG_DATA_W-1:0] kd, int unsigned n, int style,
                             int unsigned gap, bit mid_pause, bit poke_unused);
        int unsigned w, h, k, i, j, pick;
        bit paused;
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_reg(CFG_WIDTH, wd);
        write_reg(CFG_HEIGHT, hd);
        write_reg(CFG_KERNEL, kd);
        if (poke_unused)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(127, 0)));
        @(negedge i_clk);
        in_gap_pct    = gap;
        out_stall_pct = gap;
        eff_geom(w, h, k);
        for (i = 0; i < k; i++)
            for (j = 0; j < k; j++)
                push_word(MODE_WEIGHT, i, j, weight_value(style, k));
        phase_words = 0;
        paused = 1'b0;
        while (phase_words < n) begin
            if (mid_pause && !paused && phase_words >= n / 2) begin
                // sender waits for every outstanding result
                paused = 1'b1;
                drain();
                @(negedge i_clk);
            end
            pick = $urandom_range(99);
            if (pick < 55)
                queue_blur(pos_pick(h), pos_pick(w), style);
            else if (pick < 75)
                push_word(MODE_PIXEL, $urandom_range(h - 1, 0), $urandom_range(w - 1, 0),
                          $urandom_range(65536, 0));
            else if (pick < 82)
                push_word(MODE_WEIGHT, $urandom_range(k - 1, 0), $urandom_range(k - 1, 0),
                          weight_value(style, k));
            else if (pick < 84)
                push_word(MODE_WEIGHT, $urandom_range(63, KERN_MAX), $urandom_range(63, 0),
                          $urandom_range(65536, 0));
            else if (pick < 86)
                push_word(MODE_WEIGHT, $urandom_range(63, 0), $urandom_range(63, KERN_MAX),
                          $urandom_range(65536, 0));
            else if (pick < 90)
                push_word(MODE_UNUSED, $urandom_range(63, 0), $urandom_range(63, 0),
                          $urandom_range(65536, 0));
            else
                push_word(MODE_PIXEL, $urandom_range(63, 0), $urandom_range(63, 0),
                          $urandom_range(65536, 0));
        end
    endtask

    initial begin
        int unsigned r, c;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: default 64x64 frame, 3x3 kernel of unity weights
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                push_word(MODE_WEIGHT, r, c, 32'h10000);
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                push_word(MODE_PIXEL, r, c, (r == 0 && c == 0) ? 32'h0FFFF : 32'h0);
        push_word(MODE_COMPUTE, 0, 0, 0);
        push_word(MODE_PIXEL, 1, 1, 32'h00101);
        push_word(MODE_UNUSED, 63, 63, 32'h10000);
        push_word(MODE_WEIGHT, 15, 63, 32'h10000);
        push_word(MODE_WEIGHT, 0, 15, 32'h10000);
        push_word(MODE_COMPUTE, 1, 1, 32'h10000);
        push_word(MODE_PIXEL, 0, 0, 0);
        push_word(MODE_PIXEL, 1, 1, 0);
        queue_blur(2, 2, KW_NORMAL);

        run_phase(7'd8,   7'd8,   7'd3,  40,  KW_NORMAL, 20, 1'b0, 1'b0);
        run_phase(7'd0,   7'd0,   7'd0,  10,  KW_HEAVY,  10, 1'b0, 1'b0);
        run_phase(7'd127, 7'd127, 7'd5,  30,  KW_NORMAL, 25, 1'b0, 1'b0);
        run_phase(7'd20,  7'd18,  7'd15, 260, KW_SPIKY,  20, 1'b0, 1'b0);
        run_phase(7'd5,   7'd9,   7'd4,  30,  KW_SPIKY,  30, 1'b0, 1'b0);
        run_phase(7'd3,   7'd20,  7'd7,  20,  KW_HEAVY,  15, 1'b0, 1'b0);
        run_phase(7'd16,  7'd16,  7'd5,  40,  KW_NORMAL, 20, 1'b1, 1'b1);
        run_phase(7'd1,   7'd64,  7'd15, 10,  KW_HEAVY,  10, 1'b0, 1'b0);
        run_phase(7'd64,  7'd2,   7'd2,  20,  KW_NORMAL, 20, 1'b0, 1'b0);
        // steady stretch, kernel data with upper bits set
        run_phase(7'd12,  7'd10,  7'h17, 40,  KW_NORMAL, 0,  1'b0, 1'b0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
